[hdl/shash_pkg.sv]
// ----------------------------------------------------------------------------
// shash_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shash_pkg;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUND,
		ST_UPDATE
	} state_t;

	// Source of the byte shifted into the block buffer
	typedef enum logic [1:0] {
		SRC_IN,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       push;
		byte_src_t  src;
		logic       count;
		logic       round;
		logic       update;
		logic       last_blk;
		logic [5:0] k_idx;
		logic [2:0] len_idx;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [5:0] fill;
	} dp_stat_t;

	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] PAD_END    = 6'd56;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] LEN_LAST   = 3'd7;
	localparam logic [2:0] WORD_LAST  = 3'd7;
	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	localparam logic [31:0] H_INIT [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		case (idx)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage

[hdl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream. A request carries at most one message byte and
// may close the message; the digest leaves as eight 32-bit words, word 0
// first, the eighth marked with last_word. While idle, the input takes a new
// byte with every request. The 64th byte of a block starts the compression:
// 64 rounds through the single round unit, then a fold into the chaining
// words, with the input stalled. Finish adds the padding bytes one per cycle
// up to the end of the block (plus a whole extra block when fewer than nine
// bytes remain) and a final compression. The digest then sits in its own
// output register, so the next message can start while it drains; a second
// digest waits only if the previous one has not been fully taken.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        finish,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        last_word
);
	import shash_pkg::*;

	dp_cmd_t      cmd;
	dp_stat_t     stat;
	logic         out_busy;
	logic         dig_load;
	logic [255:0] digest;

	shash_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.byte_valid (byte_valid),
		.finish     (finish),
		.in_stall   (in_stall),
		.stat       (stat),
		.out_busy   (out_busy),
		.cmd        (cmd)
	);

	shash_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.stat      (stat),
		.dig_load  (dig_load),
		.digest    (digest)
	);

	shash_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (dig_load),
		.digest      (digest),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.last_word   (last_word),
		.busy        (out_busy)
	);

endmodule

[hdl/shash_ctrl.sv]
// ----------------------------------------------------------------------------
// shash_ctrl
// Sequencer: byte intake, padding, 64-round compression and digest hand-off.
// ----------------------------------------------------------------------------
module shash_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               byte_valid,
	input  logic               finish,
	output logic               in_stall,
	input  shash_pkg::dp_stat_t stat,
	input  logic               out_busy,
	output shash_pkg::dp_cmd_t  cmd
);
	import shash_pkg::*;

	state_t     state_q, state_d, ret_q;
	logic [5:0] round_q;
	logic [2:0] len_q;
	logic       last_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && byte_valid && stat.fill == FILL_LAST) begin
					state_d = ST_ROUND;
				end else if (in_valid && finish) begin
					state_d = ST_PAD_MARK;
				end
			end
			ST_PAD_MARK: begin
				state_d = (stat.fill == FILL_LAST) ? ST_ROUND : ST_PAD_ZERO;
			end
			ST_PAD_ZERO: begin
				if (stat.fill == PAD_END) begin
					state_d = ST_PAD_LEN;
				end else if (stat.fill == FILL_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_PAD_LEN: begin
				if (len_q == LEN_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == ROUND_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// hold the final sum until the previous digest has drained
				if (!(last_q && out_busy)) begin
					state_d = last_q ? ST_IDLE : ret_q;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall     = 1'b1;
		cmd          = '0;
		cmd.src      = SRC_IN;
		cmd.k_idx    = round_q;
		cmd.len_idx  = len_q;
		cmd.last_blk = last_q;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.push  = in_valid && byte_valid;
				cmd.count = in_valid && byte_valid;
			end
			ST_PAD_MARK: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_MARK;
			end
			ST_PAD_ZERO: begin
				cmd.push = (stat.fill != PAD_END);
				cmd.src  = SRC_ZERO;
			end
			ST_PAD_LEN: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = !(last_q && out_busy);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			round_q <= '0;
			len_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (state_q == ST_PAD_LEN) begin
				len_q <= len_q + 3'd1;
			end
			// remember where to resume once this block is compressed
			if (state_q != ST_ROUND && state_d == ST_ROUND) begin
				last_q <= (state_q == ST_PAD_LEN);
				if (state_q == ST_IDLE) begin
					ret_q <= finish ? ST_PAD_MARK : ST_IDLE;
				end else begin
					ret_q <= ST_PAD_ZERO;
				end
			end
		end
	end

endmodule

[hdl/shash_dpath.sv]
// ----------------------------------------------------------------------------
// shash_dpath
// Block buffer / message schedule, working variables, chaining words and
// message bit count.
// ----------------------------------------------------------------------------
module shash_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  shash_pkg::dp_cmd_t  cmd,
	input  logic [7:0]          data_byte,
	output shash_pkg::dp_stat_t stat,
	output logic                dig_load,
	output logic [255:0]        digest
);
	import shash_pkg::*;

	logic [511:0] buf_q;
	logic [31:0]  work_q [0:7];
	logic [31:0]  chain_q [0:7];
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;

	logic [7:0]   byte_in;
	logic [5:0]   len_base;
	logic [31:0]  w0, w1, w9, w14, w_new;
	logic [31:0]  t1, t2, ch, maj;

	assign len_base = {LEN_LAST - cmd.len_idx, 3'b000};

	always_comb begin
		case (cmd.src)
			SRC_IN:   byte_in = data_byte;
			SRC_MARK: byte_in = PAD_BYTE;
			SRC_ZERO: byte_in = 8'h00;
			SRC_LEN:  byte_in = bits_q[len_base +: 8];
			default:  byte_in = 8'h00;
		endcase
	end

	// Oldest schedule word sits in the top 32 bits
	assign w0  = buf_q[511:480];
	assign w1  = buf_q[479:448];
	assign w9  = buf_q[223:192];
	assign w14 = buf_q[63:32];
	assign w_new = w0 + ssig0(w1) + w9 + ssig1(w14);

	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^
		(work_q[1] & work_q[2]);
	assign t1  = work_q[7] + bsig1(work_q[4]) + ch + round_k(cmd.k_idx) + w0;
	assign t2  = bsig0(work_q[0]) + maj;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			digest[255 - 32 * i -: 32] = chain_q[i] + work_q[i];
		end
	end

	assign dig_load  = cmd.update && cmd.last_blk;
	assign stat.fill = fill_q;

	// Buffer and working variables
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			buf_q <= {buf_q[503:0], byte_in};
			// stage the chaining words for the next compression
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			buf_q     <= {buf_q[479:0], w_new};
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count) begin
				bits_q <= bits_q + BYTE_BITS;
			end
			if (cmd.update) begin
				if (cmd.last_blk) begin
					bits_q <= '0;
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= H_INIT[i];
					end
				end else begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
			end
		end
	end

endmodule

[hdl/shash_outq.sv]
// ----------------------------------------------------------------------------
// shash_outq
// Digest output register: holds eight words and hands them out in order.
// ----------------------------------------------------------------------------
module shash_outq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [255:0] digest,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  digest_word,
	output logic         last_word,
	output logic         busy
);
	import shash_pkg::*;

	logic [255:0] words_q;
	logic [2:0]   cnt_q;
	logic         valid_q;
	logic         take;

	assign take        = valid_q && !out_stall;
	assign out_valid   = valid_q;
	assign busy        = valid_q;
	assign digest_word = words_q[255:224];
	assign last_word   = (cnt_q == WORD_LAST);

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= digest;
		end else if (take) begin
			words_q <= {words_q[223:0], 32'h0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				cnt_q   <= '0;
			end else if (take) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == WORD_LAST) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

endmodule

[tb/tb_sha256_pkg.sv]
// ----------------------------------------------------------------------------
// tb_sha256_pkg
// Digest predictor for the SHA-256 stream hasher bench. It keeps its own copy
// of the block buffer, fill count, bit length and chaining words, and pads
// and compresses each message. It queues the eight digest words that every
// finished message should produce and checks the returned words in order.
// ----------------------------------------------------------------------------
package tb_sha256_pkg;

	localparam bit [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		bit [31:0] word;
		bit        marked;
	} digest_beat_t;

	class sha256_digest_board;
		bit [31:0]    chain [8];
		bit [7:0]     blk [64];
		int           fill;
		bit [63:0]    msg_bits;
		digest_beat_t digest_words [$];
		int           mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++)
				chain[i] = shash_pkg::H_INIT[i];
			fill = 0;
			msg_bits = '0;
		endfunction

		function bit [31:0] ror(bit [31:0] x, int unsigned n);
			bit [63:0] twice;
			twice = {x, x} >> n;
			return twice[31:0];
		endfunction

		function void fold_block();
			bit [31:0] w [64];
			bit [31:0] s [8];
			bit [31:0] t1, t2, s0, s1;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			s = chain;
			for (int i = 0; i < 64; i++) begin
				t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
					+ ((s[4] & s[5]) ^ (~s[4] & s[6])) + ROUND_CONST[i] + w[i];
				t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
					+ ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
				s[7] = s[6];
				s[6] = s[5];
				s[5] = s[4];
				s[4] = s[3] + t1;
				s[3] = s[2];
				s[2] = s[1];
				s[1] = s[0];
				s[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] += s[i];
		endfunction

		// Note one accepted request; a finish queues the eight digest words.
		function void absorb_request(bit [7:0] b, bit bv, bit fin);
			if (bv) begin
				blk[fill] = b;
				fill++;
				msg_bits += 64'd8;
				if (fill == 64) begin
					fold_block();
					fill = 0;
				end
			end
			if (!fin)
				return;
			blk[fill] = 8'h80;
			fill++;
			// no room left for the length: close this block, start another
			if (fill > 56) begin
				for (int i = fill; i < 64; i++)
					blk[i] = 8'h00;
				fold_block();
				fill = 0;
			end
			for (int i = fill; i < 56; i++)
				blk[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk[63-i] = msg_bits[8*i +: 8];
			fold_block();
			for (int i = 0; i < 8; i++)
				digest_words.push_back(digest_beat_t'{word: chain[i], marked: (i == 7)});
			restart();
		endfunction

		function void check_word(logic [31:0] w, logic l);
			digest_beat_t want;
			if (digest_words.size() == 0) begin
				$error("digest_word %08h arrived with no digest pending", w);
				mismatches++;
				return;
			end
			want = digest_words.pop_front();
			if (w !== want.word) begin
				$error("digest_word: expected %08h, got %08h", want.word, w);
				mismatches++;
			end
			if (l !== want.marked) begin
				$error("last_word: expected %0b, got %0b", want.marked, l);
				mismatches++;
			end
		endfunction

		function int pending();
			return digest_words.size();
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Bench for the SHA-256 stream hasher. A short directed run covers the empty
// message, byte and finish in one request, finish on its own, ignored
// requests and extreme byte values; random messages follow, mostly short,
// some sized around the padding and block boundaries. Both handshakes idle
// and stall at random, and every digest word is checked against the
// predictor in tb_sha256_pkg.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tb_sha256_pkg::*;

	localparam int RANDOM_REQUESTS = 130;
	localparam int MAX_WAIT        = 18;
	localparam int QUIET_LIMIT     = 3000;
	localparam int DRAIN_CYCLES    = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        finish;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic        last_word;

	sha256_digest_board board = new();
	bit send_steady;
	bit recv_steady;
	int random_items;

	sha256_stream_hasher u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.finish      (finish),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.last_word   (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait(bit steady);
		return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	task automatic send_request(input logic [7:0] b, input logic bv, input logic fin);
		int gap;
		gap = draw_wait(send_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		byte_valid <= bv;
		finish     <= fin;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.absorb_request(b, bv, fin);
	endtask

	task automatic send_random_message(input int len);
		bit tie;
		tie = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			// drop in an ignored request now and then
			if ($urandom_range(0, 7) == 0) begin
				send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				random_items++;
			end
			send_request(8'($urandom_range(0, 255)), 1'b1, tie && (i == len - 1));
			random_items++;
		end
		if (!tie) begin
			send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			random_items++;
		end
	endtask

	// Request side: reset, directed messages, random messages, drain.
	initial begin
		int len;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		data_byte  <= 8'h00;
		byte_valid <= 1'b0;
		finish     <= 1'b0;
		send_steady = 1'b0;
		random_items = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'hff, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'h7f, 1'b1, 1'b0);
		send_request(8'h01, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'h5a, 1'b0, 1'b0);
		send_request(8'ha5, 1'b0, 1'b1);
		send_request(8'h3c, 1'b0, 1'b1);

		while (random_items < RANDOM_REQUESTS) begin
			send_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 4))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					3: len = 64;
					default: len = 65;
				endcase
			end else begin
				len = $urandom_range(0, 20);
			end
			send_random_message(len);
		end
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Digest side: stall a random number of cycles before taking each word.
	initial begin
		int hold;
		out_stall <= 1'b1;
		recv_steady = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				recv_steady = !recv_steady;
			hold = draw_wait(recv_steady);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			board.check_word(digest_word, last_word);
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
